>>> hdl/lldq_pkg.sv
// Shared widths, codes and handshake structs for the least-loaded dispatch queues.
package lldq_pkg;

  localparam int unsigned LOAD_W    = 20;
  localparam int unsigned JOB_W     = 16;
  // Wide enough for the largest supported server count (64).
  localparam int unsigned SRV_IDX_W = 6;
  localparam int unsigned ACT_W     = 4;

  localparam logic CMD_ARRIVE   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Running minimum that walks down the cell chain during dispatch.
  typedef struct packed {
    logic                 valid;
    logic                 have;
    logic [LOAD_W-1:0]    load;
    logic [SRV_IDX_W-1:0] idx;
  } scan_t;

  // Operation broadcast to the cells; only the target cell acts on it.
  typedef struct packed {
    logic                 valid;
    logic                 op;
    logic [SRV_IDX_W-1:0] target;
    logic [JOB_W-1:0]     num;
    logic [JOB_W-1:0]     jtime;
  } cmd_t;

  // Outcome reported by a cell after an operation.
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [JOB_W-1:0]  num;
    logic [JOB_W-1:0]  jtime;
    logic [LOAD_W-1:0] load;
  } resp_t;

endpackage

>>> hdl/lldq_intf.sv
// Valid/ready channel interfaces for job requests and dispatch results.
interface lldq_in_if import lldq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [JOB_W-1:0] service_time;
  logic [2:0]       server_select;

  modport source (output valid, cmd, service_time, server_select, input ready);
  modport sink   (input valid, cmd, service_time, server_select, output ready);
endinterface

interface lldq_out_if import lldq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [2:0]        server;
  logic [JOB_W-1:0]  job_number;
  logic [JOB_W-1:0]  job_time;
  logic [LOAD_W-1:0] server_load;

  modport source (output valid, status, server, job_number, job_time, server_load,
                  input ready);
  modport sink   (input valid, status, server, job_number, job_time, server_load,
                  output ready);
endinterface

>>> hdl/least_loaded_dispatch_queues.sv
// Least-loaded job dispatcher: one ring queue per server cell, minimum-load scan down the chain.
// Each server is a cell holding its load, queue pointers and QUEUE_DEPTH-entry job store. An
// arrive beat sends a running minimum down the cell chain, one cell per cycle, and then acts on
// the chosen cell; a complete beat skips the scan and goes to the selected cell, which answers
// directly on an empty queue and after the registered read of the queue store on a pop (a server
// index of MAX_SERVERS or more gets an empty result without any cell). The last step waits until
// the output register is free. One item is in flight at a time; the next is accepted while the
// previous result still waits at the output register. The job store has no reset; only entries
// that hold queued jobs are ever popped.
module least_loaded_dispatch_queues import lldq_pkg::*; #(
  parameter int unsigned MAX_SERVERS = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ACT_W-1:0] cfg_wdata_i,
  lldq_in_if.sink          job_i,
  lldq_out_if.source       res_o
);

  localparam int unsigned SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [ACT_W-1:0]     active_q, active_d;
  logic [JOB_W-1:0]     next_num_q, next_num_d;
  logic                 op_q, op_d;
  logic [JOB_W-1:0]     num_q, num_d;
  logic [JOB_W-1:0]     time_q, time_d;
  logic [SRV_IDX_W-1:0] target_q, target_d;
  resp_t                res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  resp_t                out_q, out_d;
  logic [2:0]           out_srv_q, out_srv_d;

  scan_t                scan_start;
  scan_t                scan_arr [MAX_SERVERS];
  resp_t                resp_arr [MAX_SERVERS];
  resp_t                resp_sel;
  cmd_t                 cmd;
  logic                 accept, unknown_sel;

  assign job_i.ready = (state_q == S_IDLE);
  assign accept      = job_i.valid && job_i.ready;
  assign unknown_sel = 32'(job_i.server_select) >= 32'(MAX_SERVERS);

  assign scan_start = '{valid: accept && (job_i.cmd == CMD_ARRIVE), have: 1'b0,
                        load: '0, idx: '0};

  assign cmd = '{valid: (state_q == S_EXEC), op: op_q, target: target_q,
                 num: num_q, jtime: time_q};

  assign resp_sel = resp_arr[target_q[SRV_W-1:0]];

  for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
    scan_t scan_in;
    if (k == 0) begin : g_head
      assign scan_in = scan_start;
    end else begin : g_link
      assign scan_in = scan_arr[k-1];
    end
    lldq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .INDEX       (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active_q),
      .scan_i   (scan_in),
      .scan_o   (scan_arr[k]),
      .cmd_i    (cmd),
      .resp_o   (resp_arr[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    active_d    = cfg_we_i ? cfg_wdata_i : active_q;
    next_num_d  = next_num_q;
    op_d        = op_q;
    num_d       = num_q;
    time_d      = time_q;
    target_d    = target_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_srv_d   = out_srv_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = job_i.cmd;
          time_d   = job_i.service_time;
          target_d = SRV_IDX_W'(job_i.server_select);
          if (job_i.cmd == CMD_ARRIVE) begin
            // Drop or not, the arrival uses up its job number.
            num_d      = next_num_q;
            next_num_d = next_num_q + 1'b1;
            state_d    = S_SCAN;
          end else if (unknown_sel) begin
            res_d   = '{valid: 1'b1, status: ST_EMPTY, num: '0, jtime: '0, load: '0};
            state_d = S_DONE;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (scan_arr[MAX_SERVERS-1].valid) begin
          target_d = scan_arr[MAX_SERVERS-1].idx;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (resp_sel.valid) begin
          res_d   = resp_sel;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_srv_d   = 3'(target_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACT_W'(8);
      next_num_q  <= JOB_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      next_num_q  <= next_num_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    num_q     <= num_d;
    time_q    <= time_d;
    target_q  <= target_d;
    res_q     <= res_d;
    out_q     <= out_d;
    out_srv_q <= out_srv_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_q.status;
  assign res_o.server      = out_srv_q;
  assign res_o.job_number  = out_q.num;
  assign res_o.job_time    = out_q.jtime;
  assign res_o.server_load = out_q.load;

endmodule

>>> hdl/lldq_cell.sv
// One server cell: load, ring queue storage and one stage of the minimum-load scan.
module lldq_cell import lldq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned INDEX       = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ACT_W-1:0] active_i,
  input  scan_t            scan_i,
  output scan_t            scan_o,
  input  cmd_t             cmd_i,
  output resp_t            resp_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [LOAD_W-1:0]  load_q, load_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop_q, pop_d;
  resp_t              resp_q, resp_d;
  scan_t              scan_q, scan_d;

  logic [2*JOB_W-1:0] mem [QUEUE_DEPTH];
  logic [2*JOB_W-1:0] rd_q;

  logic               hit, active, full, wr_en;
  logic [LOAD_W:0]    add_sum;
  logic [LOAD_W-1:0]  add_sat, sub_res, pop_time;
  logic [SUM_W-1:0]   slot_sum, slot_wrap;
  logic [PTR_W-1:0]   slot, head_next;

  assign hit    = cmd_i.valid && (cmd_i.target == SRV_IDX_W'(INDEX));
  assign active = (INDEX == 0) || (32'(active_i) > 32'(INDEX));
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign wr_en  = hit && (cmd_i.op == CMD_ARRIVE) && !full;

  assign add_sum  = (LOAD_W + 1)'(load_q) + (LOAD_W + 1)'(cmd_i.jtime);
  assign add_sat  = add_sum[LOAD_W] ? '1 : add_sum[LOAD_W-1:0];
  assign pop_time = LOAD_W'(rd_q[JOB_W-1:0]);
  assign sub_res  = (load_q >= pop_time) ? (load_q - pop_time) : '0;

  // Tail slot is head + count, folded back into the ring.
  assign slot_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign slot_wrap = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? (slot_sum - SUM_W'(QUEUE_DEPTH))
                                                       : slot_sum;
  assign slot      = slot_wrap[PTR_W-1:0];
  assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (head_q + 1'b1);

  always_comb begin
    scan_d = scan_i;
    if (scan_i.valid && active && (!scan_i.have || (load_q < scan_i.load))) begin
      scan_d.have = 1'b1;
      scan_d.load = load_q;
      scan_d.idx  = SRV_IDX_W'(INDEX);
    end
  end

  always_comb begin
    load_d  = load_q;
    head_d  = head_q;
    count_d = count_q;
    pop_d   = 1'b0;
    resp_d  = '0;
    if (pop_q) begin
      // Head entry read last cycle: retire it.
      head_d  = head_next;
      count_d = count_q - 1'b1;
      load_d  = sub_res;
      resp_d  = '{valid: 1'b1, status: ST_OK, num: rd_q[2*JOB_W-1:JOB_W],
                  jtime: rd_q[JOB_W-1:0], load: sub_res};
    end else if (hit) begin
      case (cmd_i.op)
        CMD_ARRIVE: begin
          if (full) begin
            resp_d = '{valid: 1'b1, status: ST_FULL, num: cmd_i.num,
                       jtime: cmd_i.jtime, load: load_q};
          end else begin
            count_d = count_q + 1'b1;
            load_d  = add_sat;
            resp_d  = '{valid: 1'b1, status: ST_OK, num: cmd_i.num,
                        jtime: cmd_i.jtime, load: add_sat};
          end
        end
        CMD_COMPLETE: begin
          if (count_q == '0) begin
            resp_d = '{valid: 1'b1, status: ST_EMPTY, num: '0, jtime: '0, load: load_q};
          end else begin
            pop_d = 1'b1;
          end
        end
        default: begin
          resp_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot] <= {cmd_i.num, cmd_i.jtime};
    end
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
      pop_q   <= 1'b0;
      resp_q  <= '0;
      scan_q  <= '0;
    end else begin
      load_q  <= load_d;
      head_q  <= head_d;
      count_q <= count_d;
      pop_q   <= pop_d;
      resp_q  <= resp_d;
      scan_q  <= scan_d;
    end
  end

  assign scan_o = scan_q;
  assign resp_o = resp_q;

endmodule
